[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("heat stencil sweep check failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("heat stencil sweep check failed");

`endif

[rtl/hss_pkg.sv]
// Shared constants, beat types and control struct of the heat stencil sweep unit.
package hss_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int TEMP_W     = 24;
    localparam int SIZE_W     = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int IDX_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W      = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;
    localparam int SUM_W      = TEMP_W + 2;
    localparam int WIDE_W     = TEMP_W + 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PLATE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLATE_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_THRESHOLD = 2'd2;

    localparam int MIN_SIZE     = 3;
    localparam int WIDTH_RESET  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam int HEIGHT_RESET = 4096;
    localparam logic [TEMP_W-1:0] THRESHOLD_RESET = 24'd6554;
    localparam logic [TEMP_W-1:0] COUNT_MAX       = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);

    typedef struct packed {
        logic [TEMP_W-1:0] cell_temp;
        logic              cell_held;
    } cell_t;

    typedef struct packed {
        logic [TEMP_W-1:0] new_temp;
        logic              not_settled;
        logic              sweep_last;
        logic [TEMP_W-1:0] unsettled_total;
    } result_t;

    // one classified cell on its way from front to back
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              held;
        logic [COL_W-1:0]  col;
        logic              interior;
        logic              emit_up;
        logic              last_row;
        logic              last_col;
    } job_t;

    typedef struct packed {
        logic              restart;
        logic [TEMP_W-1:0] threshold;
    } ctl_t;

endpackage

[rtl/heat_stencil_sweep_unit.sv]
// Top level of the heat stencil sweep unit: front end, job queue and stencil back end.
//
//  channel  | valid / stall              | payload              | beat
//  ---------+----------------------------+----------------------+---------------------------
//  cell     | cell_valid / cell_stall    | cell_data (cell_t)   | one plate cell, raster order
//  result   | result_valid / result_stall| result (result_t)    | one updated cell
//  cfg      | cfg_we                     | cfg_index/cfg_data   | one register write
//
//  One cell beat per cycle unless cell_stall is high; rows below the first give one result
//  beat per cell, the last row two, so there the single result port paces the cells.
//  A cell's first result beat is registered in turn in the job queue, line store read,
//  sum, diff and result buffer, and a stall can hold it at any of them.
//  Reset clears counters and queues, presets the config; line stores need no clearing pass.
//  A result stall fills the four-beat result buffer, then the back end, then the queue,
//  and only then raises cell_stall.
module heat_stencil_sweep_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cell_valid,
    output logic                           cell_stall,
    input  hss_pkg::cell_t                 cell_data,
    output logic                           result_valid,
    input  logic                           result_stall,
    output hss_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hss_pkg::*;

    logic queue_full;
    logic job_push;
    job_t job;
    logic q_valid;
    job_t q_data;
    logic q_pop;
    ctl_t ctl;

    hss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_data  (cell_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (job),
        .ctl        (ctl)
    );

    hss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .wr_data (job),
        .full    (queue_full),
        .valid   (q_valid),
        .rd_data (q_data),
        .pop     (q_pop)
    );

    hss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .ctl          (ctl),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[rtl/hss_front.sv]
// Front end: configuration registers, raster position counters and cell classification.
module hss_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cell_valid,
    output logic                           cell_stall,
    input  hss_pkg::cell_t                 cell_data,
    input  logic                           cfg_we,
    input  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           queue_full,
    output logic                           job_push,
    output hss_pkg::job_t                  job,
    output hss_pkg::ctl_t                  ctl
);
    import hss_pkg::*;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [TEMP_W-1:0] threshold_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic accept;
    logic cfg_hit;
    logic last_col;
    logic last_row;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [CMP_W-1:0]  top);
        logic [CMP_W-1:0] vw;
        vw = CMP_W'(v);
        if (vw < CMP_W'(MIN_SIZE))
            return SIZE_W'(MIN_SIZE);
        else if (vw > top)
            return top[SIZE_W-1:0];
        else
            return v;
    endfunction

    assign accept     = cell_valid && !queue_full;
    assign cell_stall = queue_full;
    assign job_push   = accept;

    assign last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(width_reg);
    assign last_row = (CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(height_reg);

    always_comb
    begin
        job.temp     = cell_data.cell_temp;
        job.held     = cell_data.cell_held;
        job.col      = col_reg;
        job.interior = (row_reg > ROW_W'(1)) && (col_reg != '0) && !last_col;
        job.emit_up  = (row_reg != '0);
        job.last_row = last_row;
        job.last_col = last_col;
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_PLATE_WIDTH, REG_PLATE_HEIGHT, REG_SETTLE_THRESHOLD: cfg_hit = cfg_we;
            default: cfg_hit = 1'b0;
        endcase
    end

    assign ctl.restart   = cfg_hit;
    assign ctl.threshold = threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SIZE_W'(WIDTH_RESET);
            height_reg    <= SIZE_W'(HEIGHT_RESET);
            threshold_reg <= THRESHOLD_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else if (cfg_hit)
        begin
            unique case (cfg_index)
                REG_PLATE_WIDTH:
                    width_reg <= clamp_size(cfg_data[SIZE_W-1:0], CMP_W'(MAX_WIDTH));
                REG_PLATE_HEIGHT:
                    height_reg <= clamp_size(cfg_data[SIZE_W-1:0], CMP_W'(MAX_HEIGHT));
                REG_SETTLE_THRESHOLD:
                    threshold_reg <= cfg_data[TEMP_W-1:0];
                default:
                    threshold_reg <= threshold_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

endmodule

[rtl/hss_queue.sv]
// Short job queue between the classifying front end and the stencil back end.
module hss_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hss_pkg::job_t wr_data,
    output logic          full,
    output logic          valid,
    output hss_pkg::job_t rd_data,
    input  logic          pop
);
    import hss_pkg::*;

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    assign full    = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            count_reg <= count_reg + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
        end
    end

endmodule

[rtl/hss_back.sv]
// Back end: line stores, three-stage stencil datapath, unsettled count and result buffer.
module hss_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  hss_pkg::job_t    q_data,
    output logic             q_pop,
    input  hss_pkg::ctl_t    ctl,
    output logic             result_valid,
    input  logic             result_stall,
    output hss_pkg::result_t result
);
    import hss_pkg::*;

    // line stores: bit TEMP_W is the held flag
    logic [TEMP_W:0] line_centre_reg [MAX_WIDTH];
    logic [TEMP_W:0] line_above_reg  [MAX_WIDTH];
    logic [TEMP_W:0] cen_rd_reg;
    logic [TEMP_W:0] right_rd_reg;
    logic [TEMP_W:0] above_rd_reg;
    logic [COL_W-1:0] right_addr;

    logic adv;
    logic s1_adv;
    logic s2_adv;
    logic s3_adv;

    // stage 1: line store data present
    logic              s1_valid_reg;
    job_t              s1_job_reg;
    logic [TEMP_W-1:0] left_reg;
    logic [SUM_W-1:0]  s1_sum;
    logic              s1_active;

    // stage 2: neighbour sum
    logic              s2_valid_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic [TEMP_W-1:0] s2_cval_reg;
    logic [TEMP_W-1:0] s2_down_reg;
    logic              s2_active_reg;
    logic              s2_emit_up_reg;
    logic              s2_last_row_reg;
    logic              s2_last_col_reg;
    logic [WIDE_W-1:0] s2_four_c;
    logic [WIDE_W-1:0] s2_sum_w;
    logic [WIDE_W-1:0] s2_diff;
    logic [WIDE_W-1:0] s2_total;

    // stage 3: difference and new value
    logic              s3_valid_reg;
    logic [WIDE_W-1:0] s3_diff_reg;
    logic [TEMP_W-1:0] s3_new_reg;
    logic [TEMP_W-1:0] s3_down_reg;
    logic              s3_active_reg;
    logic              s3_emit_up_reg;
    logic              s3_last_row_reg;
    logic              s3_last_col_reg;
    logic              s3_unsettled;
    logic              s3_sweep_end;

    logic [TEMP_W-1:0] count_reg;
    logic [TEMP_W-1:0] count_new;

    result_t              out_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_reg;
    logic [OUT_PTR_W-1:0] out_rd_reg;
    logic [OUT_PTR_W:0]   out_count_reg;
    logic                 push_a;
    logic                 push_b;
    logic                 out_pop;
    result_t              beat_a;
    result_t              beat_b;

    // advance only with room for the two beats a last-row cell makes
    assign adv    = out_count_reg <= (OUT_PTR_W+1)'(OUT_DEPTH - 2);
    assign q_pop  = adv && q_valid;
    assign s1_adv = adv && s1_valid_reg;
    assign s2_adv = adv && s2_valid_reg;
    assign s3_adv = adv && s3_valid_reg;

    assign right_addr = q_data.col + COL_W'(1);

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cen_rd_reg                  <= line_centre_reg[q_data.col];
            right_rd_reg                <= line_centre_reg[right_addr];
            line_centre_reg[q_data.col] <= {q_data.held, q_data.temp};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            above_rd_reg <= line_above_reg[q_data.col];
        if (s1_adv)
            line_above_reg[s1_job_reg.col] <= cen_rd_reg;
    end

    assign s1_sum = SUM_W'(left_reg) + SUM_W'(right_rd_reg[TEMP_W-1:0])
                  + SUM_W'(above_rd_reg[TEMP_W-1:0]) + SUM_W'(s1_job_reg.temp);
    assign s1_active = s1_job_reg.interior && !cen_rd_reg[TEMP_W];

    assign s2_four_c = {1'b0, s2_cval_reg, 2'b00};
    assign s2_sum_w  = WIDE_W'(s2_sum_reg);
    assign s2_diff   = (s2_four_c >= s2_sum_w) ? s2_four_c - s2_sum_w : s2_sum_w - s2_four_c;
    assign s2_total  = s2_four_c + s2_sum_w;

    assign s3_unsettled = s3_active_reg && (s3_diff_reg > {1'b0, ctl.threshold, 2'b00});
    assign s3_sweep_end = s3_last_row_reg && s3_last_col_reg;
    assign count_new    = count_reg + TEMP_W'(s3_unsettled && (count_reg != COUNT_MAX));

    always_ff @(posedge clk)
    begin
        if (q_pop)
            s1_job_reg <= q_data;
        if (s1_adv)
        begin
            left_reg        <= cen_rd_reg[TEMP_W-1:0];
            s2_sum_reg      <= s1_sum;
            s2_cval_reg     <= cen_rd_reg[TEMP_W-1:0];
            s2_down_reg     <= s1_job_reg.temp;
            s2_active_reg   <= s1_active;
            s2_emit_up_reg  <= s1_job_reg.emit_up;
            s2_last_row_reg <= s1_job_reg.last_row;
            s2_last_col_reg <= s1_job_reg.last_col;
        end
        if (s2_adv)
        begin
            s3_diff_reg     <= s2_diff;
            s3_new_reg      <= s2_active_reg ? s2_total[TEMP_W+2:3] : s2_cval_reg;
            s3_down_reg     <= s2_down_reg;
            s3_active_reg   <= s2_active_reg;
            s3_emit_up_reg  <= s2_emit_up_reg;
            s3_last_row_reg <= s2_last_row_reg;
            s3_last_col_reg <= s2_last_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= q_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            if (ctl.restart)
                count_reg <= '0;
            else if (s3_adv)
                count_reg <= s3_sweep_end ? '0 : count_new;
        end
    end

    // result buffer; a last-row cell writes its second beat into the slot after the first
    assign push_a  = s3_adv && s3_emit_up_reg;
    assign push_b  = s3_adv && s3_last_row_reg;
    assign out_pop = result_valid && !result_stall;

    always_comb
    begin
        beat_a.new_temp        = s3_new_reg;
        beat_a.not_settled     = s3_unsettled;
        beat_a.sweep_last      = 1'b0;
        beat_a.unsettled_total = '0;
        beat_b.new_temp        = s3_down_reg;
        beat_b.not_settled     = 1'b0;
        beat_b.sweep_last      = s3_sweep_end;
        beat_b.unsettled_total = s3_sweep_end ? count_new : '0;
    end

    assign result_valid = (out_count_reg != '0);
    assign result       = out_reg[out_rd_reg];

    always_ff @(posedge clk)
    begin
        if (push_a)
            out_reg[out_wr_reg] <= beat_a;
        if (push_b)
            out_reg[out_wr_reg + OUT_PTR_W'(1)] <= beat_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            out_wr_reg <= out_wr_reg + OUT_PTR_W'(push_a) + OUT_PTR_W'(push_b);
            if (out_pop)
                out_rd_reg <= out_rd_reg + OUT_PTR_W'(1);
            out_count_reg <= out_count_reg + (OUT_PTR_W+1)'(push_a)
                           + (OUT_PTR_W+1)'(push_b) - (OUT_PTR_W+1)'(out_pop);
        end
    end

endmodule

[rtl/hss_checker.sv]
// Port-level checker of the heat stencil sweep unit and its bind.
`include "assert_macros.svh"

module hss_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             cell_stall,
    input logic             result_valid,
    input logic             result_stall,
    input hss_pkg::result_t result
);
    import hss_pkg::*;

    `ASSERT_RUN(a_result_hold, clk, rst_n, result_valid && result_stall |=> result_valid && $stable(result))
    `ASSERT_RUN(a_total_only_last, clk, rst_n, result_valid && !result.sweep_last |-> result.unsettled_total == '0)
    `ASSERT_RUN(a_flag_not_on_last, clk, rst_n, result_valid && result.not_settled |-> !result.sweep_last)
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !result_valid && !cell_stall)

endmodule

bind heat_stencil_sweep_unit hss_checker u_hss_checker (.*);

[bench/tb.sv]
// Testbench of the heat stencil sweep unit: directed sweeps, random plates and a bit-true predictor.
module tb;
    import hss_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PREDICT       = -1;
    localparam int RANDOM_ITEMS  = 400;
    localparam int WIDE_COLS     = 128;
    localparam int TALL_CELLS    = 192;
    localparam int QUIET_LIMIT   = 2000;
    localparam int FLUSH_CYCLES  = 20;
    localparam int REPORT_LINES  = 100;

    typedef enum logic {STEP_CFG, STEP_CELL} step_e;

    typedef struct {
        step_e                 kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        cell_t                 c;
        int                    typed;
        result_t               e0;
        result_t               e1;
    } drill_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cell_valid;
    logic                  cell_stall;
    cell_t                 cell_data;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    heat_stencil_sweep_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [TEMP_W:0]   above_row  [MAX_WIDTH];
    logic [TEMP_W:0]   centre_row [MAX_WIDTH];
    logic [TEMP_W:0]   left_entry;
    int                row_at;
    int                col_at;
    int                plate_w;
    int                plate_h;
    logic [TEMP_W-1:0] threshold;
    logic [TEMP_W-1:0] unsettled;

    result_t cells_due[$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      idle_on = 1'b1;
    bit      smooth_plate;
    int      plate_base;
    int      plate_spread;

    task automatic report_mismatch(input string what, input logic [TEMP_W-1:0] got,
                                   input logic [TEMP_W-1:0] want);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
    endtask

    function automatic result_t res(input logic [TEMP_W-1:0] t, input logic ns,
                                    input logic last, input logic [TEMP_W-1:0] tot);
        result_t r;
        r.new_temp        = t;
        r.not_settled     = ns;
        r.sweep_last      = last;
        r.unsettled_total = tot;
        return r;
    endfunction

    function automatic drill_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        drill_t d;
        d.kind  = STEP_CFG;
        d.idx   = idx;
        d.data  = data;
        d.c     = '0;
        d.typed = 0;
        d.e0    = '0;
        d.e1    = '0;
        return d;
    endfunction

    function automatic drill_t cell_step(input logic [TEMP_W-1:0] t, input logic held,
                                         input int typed, input result_t e0, input result_t e1);
        drill_t d;
        d.kind          = STEP_CELL;
        d.idx           = '0;
        d.data          = '0;
        d.c.cell_temp   = t;
        d.c.cell_held   = held;
        d.typed         = typed;
        d.e0            = e0;
        d.e1            = e1;
        return d;
    endfunction

    function automatic void restart_sweep();
        row_at     = 0;
        col_at     = 0;
        unsettled  = '0;
        left_entry = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        int v;
        v = int'(data[SIZE_W-1:0]);
        if (v < MIN_SIZE)
            v = MIN_SIZE;
        case (idx)
            REG_PLATE_WIDTH:
            begin
                plate_w = (v > MAX_WIDTH) ? MAX_WIDTH : v;
                restart_sweep();
            end
            REG_PLATE_HEIGHT:
            begin
                plate_h = (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
                restart_sweep();
            end
            REG_SETTLE_THRESHOLD:
            begin
                threshold = data[TEMP_W-1:0];
                restart_sweep();
            end
            default: ;
        endcase
    endfunction

    // one accepted cell: results for the cell above it, and for itself in the last row
    function automatic void relax_cell(input cell_t c, output result_t out0,
                                       output result_t out1, output int n);
        logic [TEMP_W:0]   cen;
        logic [TEMP_W:0]   abv;
        logic [TEMP_W:0]   rgt;
        logic [27:0]       sum;
        logic [27:0]       four_c;
        logic [27:0]       diff;
        logic [27:0]       limit4;
        logic [27:0]       blend;
        logic [TEMP_W-1:0] nt;
        logic              ns;
        logic              last;
        cen  = centre_row[col_at];
        abv  = above_row[col_at];
        rgt  = (col_at + 1 < MAX_WIDTH) ? centre_row[col_at + 1] : '0;
        out0 = '0;
        out1 = '0;
        n    = 0;
        if (row_at >= 1)
        begin
            nt = cen[TEMP_W-1:0];
            ns = 1'b0;
            if (row_at >= 2 && col_at >= 1 && col_at + 1 < plate_w && !cen[TEMP_W])
            begin
                sum = 28'(left_entry[TEMP_W-1:0]) + 28'(rgt[TEMP_W-1:0])
                    + 28'(abv[TEMP_W-1:0]) + 28'(c.cell_temp);
                four_c = 28'(cen[TEMP_W-1:0]) << 2;
                diff   = (four_c >= sum) ? four_c - sum : sum - four_c;
                limit4 = 28'(threshold) << 2;
                blend  = (sum + four_c) >> 3;
                nt     = blend[TEMP_W-1:0];
                if (diff > limit4)
                begin
                    ns = 1'b1;
                    if (unsettled != COUNT_MAX)
                        unsettled = unsettled + TEMP_W'(1);
                end
            end
            out0 = res(nt, ns, 1'b0, '0);
            n = 1;
            if (row_at + 1 >= plate_h)
            begin
                last = (col_at + 1 >= plate_w);
                out1 = res(c.cell_temp, 1'b0, last, last ? unsettled : '0);
                n = 2;
            end
        end
        left_entry         = cen;
        above_row[col_at]  = cen;
        centre_row[col_at] = {c.cell_held, c.cell_temp};
        if (col_at + 1 >= plate_w)
        begin
            col_at = 0;
            if (row_at + 1 >= plate_h)
            begin
                row_at    = 0;
                unsettled = '0;
            end
            else
                row_at = row_at + 1;
        end
        else
            col_at = col_at + 1;
    endfunction

    task automatic send_cell(input cell_t c, input int typed, input result_t t0,
                             input result_t t1);
        result_t p0;
        result_t p1;
        int      n;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            cell_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_data  <= c;
        forever
        begin
            @(posedge clk);
            if (!cell_stall)
                break;
        end
        relax_cell(c, p0, p1, n);
        if (typed != PREDICT)
        begin
            n  = typed;
            p0 = t0;
            p1 = t1;
        end
        if (n >= 1)
            cells_due = {cells_due, p0};
        if (n >= 2)
            cells_due = {cells_due, p1};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // row-zero cells give no beat, so allow them to leave the pipe too
    task automatic settle_pipe();
        cell_valid <= 1'b0;
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    function automatic cell_t make_cell();
        cell_t c;
        if (smooth_plate)
            c.cell_temp = TEMP_W'(plate_base + int'($urandom_range(0, plate_spread)));
        else
            c.cell_temp = TEMP_W'($urandom);
        c.cell_held = ($urandom_range(0, 7) == 0);
        return c;
    endfunction

    task automatic retune(input bit all_regs);
        logic [CFG_DATA_W-1:0] data;
        if (all_regs || $urandom_range(0, 1) == 1)
        begin
            data = CFG_DATA_W'($urandom);
            data[SIZE_W-1:0] = SIZE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                                   : $urandom_range(3, 10));
            write_reg(REG_PLATE_WIDTH, data);
        end
        if (all_regs || $urandom_range(0, 1) == 1)
        begin
            data = CFG_DATA_W'($urandom);
            data[SIZE_W-1:0] = SIZE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                                   : $urandom_range(3, 7));
            write_reg(REG_PLATE_HEIGHT, data);
        end
        if (all_regs || $urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 5))
                0: data = '0;
                1: data = '1;
                2: data = CFG_DATA_W'($urandom);
                default: data = CFG_DATA_W'($urandom_range(0, 3000));
            endcase
            write_reg(REG_SETTLE_THRESHOLD, data);
        end
        if ($urandom_range(0, 9) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    task automatic fill_plate(input int cells);
        for (int i = 0; i < cells; i++)
            send_cell(make_cell(), PREDICT, '0, '0);
    endtask

    task automatic reshape_data();
        smooth_plate = ($urandom_range(0, 3) != 0);
        plate_base   = $urandom_range(0, 24'hF00000);
        plate_spread = $urandom_range(1, 20000);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (cells_due.size() == 0)
                report_mismatch("unexpected beat", result.new_temp, '0);
            else
            begin
                want = cells_due.pop_front();
                if (result.new_temp !== want.new_temp)
                    report_mismatch("new_temp", result.new_temp, want.new_temp);
                if (result.not_settled !== want.not_settled)
                    report_mismatch("not_settled", TEMP_W'(result.not_settled),
                                    TEMP_W'(want.not_settled));
                if (result.sweep_last !== want.sweep_last)
                    report_mismatch("sweep_last", TEMP_W'(result.sweep_last),
                                    TEMP_W'(want.sweep_last));
                if (result.unsettled_total !== want.unsettled_total)
                    report_mismatch("unsettled_total", result.unsettled_total,
                                    want.unsettled_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cell_valid && !cell_stall) || (result_valid && !result_stall) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        drill_t drill[$];
        int     random_cells;
        int     cells;
        rst_n      <= 1'b0;
        cell_valid <= 1'b0;
        cell_data  <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            above_row[i]  = '0;
            centre_row[i] = '0;
        end
        plate_w   = WIDTH_RESET;
        plate_h   = HEIGHT_RESET;
        threshold = THRESHOLD_RESET;
        restart_sweep();
        reshape_data();

        // 3x3 plate, sizes below the floor, one unsettled interior cell
        drill = {drill, cfg_step(REG_PLATE_WIDTH, 24'h000001)};
        drill = {drill, cfg_step(REG_PLATE_HEIGHT, 24'hFFE002)};
        drill = {drill, cfg_step(REG_SETTLE_THRESHOLD, 24'h000000)};
        drill = {drill, cfg_step(REG_UNUSED, 24'hFFFFFF)};
        drill = {drill, cell_step(24'h000000, 1'b0, 0, '0, '0)};
        drill = {drill, cell_step(24'hFFFFFF, 1'b0, 0, '0, '0)};
        drill = {drill, cell_step(24'h800000, 1'b1, 0, '0, '0)};
        drill = {drill, cell_step(24'hFFFFFF, 1'b1, 1,
                                  res(24'h000000, 1'b0, 1'b0, '0), '0)};
        drill = {drill, cell_step(24'h400000, 1'b0, 1,
                                  res(24'hFFFFFF, 1'b0, 1'b0, '0), '0)};
        drill = {drill, cell_step(24'h000001, 1'b0, 1,
                                  res(24'h800000, 1'b0, 1'b0, '0), '0)};
        drill = {drill, cell_step(24'hFFFFFF, 1'b0, 2, res(24'hFFFFFF, 1'b0, 1'b0, '0),
                                  res(24'hFFFFFF, 1'b0, 1'b0, '0))};
        drill = {drill, cell_step(24'h000010, 1'b1, PREDICT, '0, '0)};
        drill = {drill, cell_step(24'hABCDEF, 1'b0, 2, res(24'h000001, 1'b0, 1'b0, '0),
                                  res(24'hABCDEF, 1'b0, 1'b1, 24'h000001))};
        // next sweep follows with no write; held interior cell passes through
        drill = {drill, cell_step(24'h000000, 1'b1, 0, '0, '0)};
        drill = {drill, cell_step(24'hFFFFFF, 1'b1, 0, '0, '0)};
        drill = {drill, cell_step(24'h000000, 1'b0, 0, '0, '0)};
        drill = {drill, cell_step(24'h123456, 1'b0, 1,
                                  res(24'h000000, 1'b0, 1'b0, '0), '0)};
        drill = {drill, cell_step(24'hFFFFFF, 1'b1, 1,
                                  res(24'hFFFFFF, 1'b0, 1'b0, '0), '0)};
        drill = {drill, cell_step(24'h000000, 1'b0, 1,
                                  res(24'h000000, 1'b0, 1'b0, '0), '0)};
        drill = {drill, cell_step(24'hFFFFFF, 1'b1, 2, res(24'h123456, 1'b0, 1'b0, '0),
                                  res(24'hFFFFFF, 1'b0, 1'b0, '0))};
        drill = {drill, cell_step(24'h000007, 1'b0, 2, res(24'hFFFFFF, 1'b0, 1'b0, '0),
                                  res(24'h000007, 1'b0, 1'b0, '0))};
        drill = {drill, cell_step(24'hFFFFFF, 1'b1, 2, res(24'h000000, 1'b0, 1'b0, '0),
                                  res(24'hFFFFFF, 1'b0, 1'b1, '0))};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill[i])
        begin
            if (drill[i].kind == STEP_CFG)
            begin
                settle_pipe();
                write_reg(drill[i].idx, drill[i].data);
            end
            else
                send_cell(drill[i].c, drill[i].typed, drill[i].e0, drill[i].e1);
        end

        // wide plate, then the first rows of the tallest
        settle_pipe();
        write_reg(REG_PLATE_WIDTH, CFG_DATA_W'(WIDE_COLS));
        write_reg(REG_PLATE_HEIGHT, 24'd3);
        write_reg(REG_SETTLE_THRESHOLD, 24'd2000);
        smooth_plate = 1'b1;
        fill_plate(plate_w * plate_h);
        settle_pipe();
        write_reg(REG_PLATE_WIDTH, 24'd3);
        write_reg(REG_PLATE_HEIGHT, 24'hFFFFFF);
        smooth_plate = 1'b0;
        fill_plate(TALL_CELLS);

        random_cells = 0;
        settle_pipe();
        retune(1'b1);
        while (random_cells < RANDOM_ITEMS)
        begin
            idle_on = (random_cells < RANDOM_ITEMS * 85 / 100) && ($urandom_range(0, 3) != 0);
            reshape_data();
            if ($urandom_range(0, 1) == 1)
                cells = plate_w * plate_h * int'($urandom_range(1, 2));
            else
                cells = $urandom_range(1, 2 * plate_w * plate_h);
            fill_plate(cells);
            random_cells += cells;
            settle_pipe();
            if ($urandom_range(0, 3) != 0)
                retune(1'b0);
        end

        idle_on = 1'b0;
        settle_pipe();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/hss_pkg.sv
rtl/hss_front.sv
rtl/hss_queue.sv
rtl/hss_back.sv
rtl/heat_stencil_sweep_unit.sv
rtl/hss_checker.sv
bench/tb.sv
